// File: sv/cbt_pkg.sv
// package with the payload types and fixed constants of the bezier tessellator
`timescale 1ns / 1ps

package cbt_pkg;

  localparam int CoordBits = 24;
  localparam int StepBits = 6;
  localparam logic [StepBits-1:0] StepsReset = 6'd15;
  // remainder of the per-step t increment stays below twice the step count
  localparam int RemBits = StepBits + 1;

  typedef struct packed {
    logic signed [CoordBits-1:0] p0_x;
    logic signed [CoordBits-1:0] p0_y;
    logic signed [CoordBits-1:0] p1_x;
    logic signed [CoordBits-1:0] p1_y;
    logic signed [CoordBits-1:0] p2_x;
    logic signed [CoordBits-1:0] p2_y;
    logic signed [CoordBits-1:0] p3_x;
    logic signed [CoordBits-1:0] p3_y;
  } seg_t;

  typedef struct packed {
    logic signed [CoordBits-1:0] curve_x;
    logic signed [CoordBits-1:0] curve_y;
    logic [StepBits-1:0] step_index;
    logic last_point;
  } point_t;

  typedef struct packed {
    logic [StepBits-1:0] step;
    logic last;
  } step_ctl_t;

endpackage

// File: sv/cbt_div.sv
// bit-serial divider giving the per-step t increment for the current step count
`timescale 1ns / 1ps

module cbt_div #(
  parameter int T_FRAC_BITS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [cbt_pkg::StepBits-1:0] steps_i,
  output logic                        busy_o,
  output logic [T_FRAC_BITS:0]        inc_q_o,
  output logic [cbt_pkg::RemBits-1:0] inc_r_o
);

  localparam int TB = T_FRAC_BITS + 1;
  // dividend is 2^(T_FRAC_BITS+1), one quotient bit per cycle
  localparam int DivBits = T_FRAC_BITS + 2;
  localparam int CntW = $clog2(DivBits + 1);
  localparam int RB = cbt_pkg::RemBits;

  logic [CntW-1:0] cnt_q, cnt_d;
  logic [RB-1:0]   div_q, div_d;
  logic [RB-1:0]   rem_q, rem_d;
  logic [TB-1:0]   quo_q, quo_d;
  logic [RB:0]     rem_sh;
  logic            qbit;

  always_comb begin
    cnt_d  = cnt_q;
    div_d  = div_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    rem_sh = {rem_q, (cnt_q == CntW'(DivBits))};
    qbit   = (rem_sh >= {1'b0, div_q});
    if (cnt_q != '0) begin
      rem_d = qbit ? RB'(rem_sh - {1'b0, div_q}) : rem_sh[RB-1:0];
      quo_d = {quo_q[TB-2:0], qbit};
      cnt_d = cnt_q - 1'b1;
    end
    if (start_i) begin
      // divisor is twice the step count
      div_d = {steps_i, 1'b0};
      rem_d = '0;
      quo_d = '0;
      cnt_d = CntW'(DivBits);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= CntW'(DivBits);
      div_q <= {cbt_pkg::StepsReset, 1'b0};
      rem_q <= '0;
      quo_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      div_q <= div_d;
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign busy_o  = (cnt_q != '0);
  assign inc_q_o = quo_q;
  assign inc_r_o = rem_q;

endmodule

// File: sv/cbt_seq.sv
// point sequencer: holds one segment and issues t for j = 0..steps
`timescale 1ns / 1ps

module cbt_seq #(
  parameter int T_FRAC_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  cbt_pkg::seg_t                in_data_i,
  input  logic [cbt_pkg::StepBits-1:0] steps_i,
  input  logic                         busy_i,
  input  logic [T_FRAC_BITS:0]         inc_q_i,
  input  logic [cbt_pkg::RemBits-1:0]  inc_r_i,
  output logic                         pt_valid_o,
  input  logic                         pt_ready_i,
  output cbt_pkg::seg_t                pt_seg_o,
  output cbt_pkg::step_ctl_t           pt_ctl_o,
  output logic [T_FRAC_BITS:0]         pt_t_o
);

  localparam int TB = T_FRAC_BITS + 1;
  localparam int RB = cbt_pkg::RemBits;
  localparam int SB = cbt_pkg::StepBits;

  logic          act_q, act_d;
  cbt_pkg::seg_t seg_q, seg_d;
  logic [SB-1:0] j_q, j_d;
  logic [TB-1:0] t_q, t_d;
  logic [RB-1:0] r_q, r_d;
  logic [RB:0]   r_sum;
  logic [RB:0]   div2;
  logic          last;
  logic          adv;
  logic          acc;

  assign last       = (j_q == steps_i);
  assign adv        = act_q & pt_ready_i;
  assign in_ready_o = ~busy_i & (~act_q | (pt_ready_i & last));
  assign acc        = in_valid_i & in_ready_o;

  always_comb begin
    act_d = act_q;
    seg_d = seg_q;
    j_d   = j_q;
    t_d   = t_q;
    r_d   = r_q;
    r_sum = {1'b0, r_q} + {1'b0, inc_r_i};
    div2  = {1'b0, steps_i, 1'b0};
    if (adv) begin
      if (last) begin
        act_d = 1'b0;
      end else begin
        j_d = j_q + 1'b1;
        // numerator grows by 2^(T_FRAC_BITS+1) each step
        if (r_sum >= div2) begin
          r_d = RB'(r_sum - div2);
          t_d = t_q + inc_q_i + 1'b1;
        end else begin
          r_d = r_sum[RB-1:0];
          t_d = t_q + inc_q_i;
        end
      end
    end
    if (acc) begin
      act_d = 1'b1;
      seg_d = in_data_i;
      j_d   = '0;
      t_d   = '0;
      r_d   = {1'b0, steps_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= 1'b0;
    end else begin
      act_q <= act_d;
    end
  end

  always_ff @(posedge clk_i) begin
    seg_q <= seg_d;
    j_q   <= j_d;
    t_q   <= t_d;
    r_q   <= r_d;
  end

  assign pt_valid_o    = act_q;
  assign pt_seg_o      = seg_q;
  assign pt_ctl_o.step = j_q;
  assign pt_ctl_o.last = last;
  assign pt_t_o        = t_q;

endmodule

// File: sv/cbt_pipe.sv
// four-stage pipeline: bernstein weights, products, sum with rounding and saturation
`timescale 1ns / 1ps

module cbt_pipe #(
  parameter int T_FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               pt_valid_i,
  output logic               pt_ready_o,
  input  cbt_pkg::seg_t      pt_seg_i,
  input  cbt_pkg::step_ctl_t pt_ctl_i,
  input  logic [T_FRAC_BITS:0] pt_t_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output cbt_pkg::point_t    out_data_o
);

  localparam int C  = cbt_pkg::CoordBits;
  localparam int TF = T_FRAC_BITS;
  localparam int TB = TF + 1;
  localparam int WB = TF + 2;
  localparam int PW = WB + 1 + C;
  localparam int SW = PW + 2;
  localparam int RW = SW - TF;
  localparam logic [TB-1:0] TOne = TB'(1) << TF;
  localparam logic [2*TB-1:0] HalfP = (2*TB)'(1) << (TF - 1);
  localparam logic signed [SW-1:0] HalfS = SW'(1) << (TF - 1);

  function automatic logic [TB-1:0] rnd_mul(input logic [TB-1:0] a, input logic [TB-1:0] b);
    logic [2*TB-1:0] p;
    p = (2*TB)'(a) * (2*TB)'(b) + HalfP;
    return p[TF +: TB];
  endfunction

  logic en1, en2, en3, en4;
  logic s1_v_q, s2_v_q, s3_v_q, s4_v_q;

  logic [TB-1:0]      s1_t_q, s1_u_q, s1_t2_q, s1_u2_q;
  cbt_pkg::seg_t      s1_seg_q, s2_seg_q;
  cbt_pkg::step_ctl_t s1_ctl_q, s2_ctl_q, s3_ctl_q;
  logic [WB-1:0]      s2_w_q [4];
  logic signed [PW-1:0] s3_px_q [4];
  logic signed [PW-1:0] s3_py_q [4];
  cbt_pkg::point_t    s4_data_q;

  logic [TB-1:0] u_c;
  logic [TB-1:0] t3_c, u3_c, a_c, b_c;
  logic signed [C-1:0] px [4];
  logic signed [C-1:0] py [4];
  logic signed [SW-1:0] acc_x, acc_y;
  logic signed [RW-1:0] sh_x, sh_y;
  logic signed [C-1:0]  sat_x, sat_y;

  function automatic logic signed [C-1:0] sat(input logic signed [RW-1:0] r);
    logic signed [C-1:0] res;
    if (!r[RW-1] && (|r[RW-2:C-1])) begin
      res = {1'b0, {(C-1){1'b1}}};
    end else if (r[RW-1] && !(&r[RW-2:C-1])) begin
      res = {1'b1, {(C-1){1'b0}}};
    end else begin
      res = r[C-1:0];
    end
    return res;
  endfunction

  // each stage moves when it is empty or the next one moves
  assign en4        = ~s4_v_q | out_ready_i;
  assign en3        = ~s3_v_q | en4;
  assign en2        = ~s2_v_q | en3;
  assign en1        = ~s1_v_q | en2;
  assign pt_ready_o = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      s4_v_q <= 1'b0;
    end else begin
      if (en1) s1_v_q <= pt_valid_i;
      if (en2) s2_v_q <= s1_v_q;
      if (en3) s3_v_q <= s2_v_q;
      if (en4) s4_v_q <= s3_v_q;
    end
  end

  // stage 1: squares of t and 1-t
  assign u_c = TOne - pt_t_i;

  always_ff @(posedge clk_i) begin
    if (en1 && pt_valid_i) begin
      s1_t_q   <= pt_t_i;
      s1_u_q   <= u_c;
      s1_t2_q  <= rnd_mul(pt_t_i, pt_t_i);
      s1_u2_q  <= rnd_mul(u_c, u_c);
      s1_seg_q <= pt_seg_i;
      s1_ctl_q <= pt_ctl_i;
    end
  end

  // stage 2: cubic terms and weights
  assign t3_c = rnd_mul(s1_t2_q, s1_t_q);
  assign u3_c = rnd_mul(s1_u2_q, s1_u_q);
  assign a_c  = rnd_mul(s1_t_q, s1_u2_q);
  assign b_c  = rnd_mul(s1_t2_q, s1_u_q);

  always_ff @(posedge clk_i) begin
    if (en2 && s1_v_q) begin
      s2_w_q[0] <= WB'(u3_c);
      s2_w_q[1] <= {a_c, 1'b0} + WB'(a_c);
      s2_w_q[2] <= {b_c, 1'b0} + WB'(b_c);
      s2_w_q[3] <= WB'(t3_c);
      s2_seg_q  <= s1_seg_q;
      s2_ctl_q  <= s1_ctl_q;
    end
  end

  // stage 3: weight times control point
  assign px[0] = s2_seg_q.p0_x;
  assign px[1] = s2_seg_q.p1_x;
  assign px[2] = s2_seg_q.p2_x;
  assign px[3] = s2_seg_q.p3_x;
  assign py[0] = s2_seg_q.p0_y;
  assign py[1] = s2_seg_q.p1_y;
  assign py[2] = s2_seg_q.p2_y;
  assign py[3] = s2_seg_q.p3_y;

  always_ff @(posedge clk_i) begin
    if (en3 && s2_v_q) begin
      for (int i = 0; i < 4; i++) begin
        s3_px_q[i] <= PW'(signed'({1'b0, s2_w_q[i]})) * PW'(px[i]);
        s3_py_q[i] <= PW'(signed'({1'b0, s2_w_q[i]})) * PW'(py[i]);
      end
      s3_ctl_q <= s2_ctl_q;
    end
  end

  // stage 4: sum, round half up, floor shift, saturate
  assign acc_x = SW'(s3_px_q[0]) + SW'(s3_px_q[1]) + SW'(s3_px_q[2]) + SW'(s3_px_q[3])
                 + HalfS;
  assign acc_y = SW'(s3_py_q[0]) + SW'(s3_py_q[1]) + SW'(s3_py_q[2]) + SW'(s3_py_q[3])
                 + HalfS;
  assign sh_x  = acc_x[SW-1:TF];
  assign sh_y  = acc_y[SW-1:TF];
  assign sat_x = sat(sh_x);
  assign sat_y = sat(sh_y);

  always_ff @(posedge clk_i) begin
    if (en4 && s3_v_q) begin
      s4_data_q.curve_x    <= sat_x;
      s4_data_q.curve_y    <= sat_y;
      s4_data_q.step_index <= s3_ctl_q.step;
      s4_data_q.last_point <= s3_ctl_q.last;
    end
  end

  assign out_valid_o = s4_v_q;
  assign out_data_o  = s4_data_q;

endmodule

// File: sv/cubic_bezier_tessellator_top.sv
// top level of the cubic bezier tessellator
//
// in channel: one transfer carries a segment of four control points (in_data_i).
// out channel: each segment yields steps+1 points, j = 0..steps, in order of j;
// the point with j equal to steps has last_point set.
// cfg_we_i/cfg_wdata_i write the step count (0 acts as 1); write only while idle.
// the point j = 0 is registered by the point sequencer and by each pipeline stage.
// throughput: one point per cycle while the receiver does not stall; the point
// sequencer sets this rate, and the next segment is taken in the cycle its last
// point enters the pipeline.
// after reset and after each step-count write, a bit-serial divider works out
// the t increment, with in_ready_o low meanwhile.
// when the receiver stalls, the four pipeline stages fill up and then
// in_ready_o drops; nothing is lost or repeated.
`timescale 1ns / 1ps

module cubic_bezier_tessellator_top #(
  parameter int T_FRAC_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  cbt_pkg::seg_t                in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output cbt_pkg::point_t              out_data_o,
  input  logic                         cfg_we_i,
  input  logic [cbt_pkg::StepBits-1:0] cfg_wdata_i
);

  localparam int SB = cbt_pkg::StepBits;

  logic [SB-1:0]              steps_q;
  logic [SB-1:0]              wr_steps;
  logic                       busy;
  logic [T_FRAC_BITS:0]       inc_q;
  logic [cbt_pkg::RemBits-1:0] inc_r;
  logic                       pt_valid;
  logic                       pt_ready;
  cbt_pkg::seg_t              pt_seg;
  cbt_pkg::step_ctl_t         pt_ctl;
  logic [T_FRAC_BITS:0]       pt_t;

  // a step count of zero is taken as one
  assign wr_steps = (cfg_wdata_i == '0) ? SB'(1) : cfg_wdata_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      steps_q <= cbt_pkg::StepsReset;
    end else if (cfg_we_i) begin
      steps_q <= wr_steps;
    end
  end

  cbt_div #(
    .T_FRAC_BITS(T_FRAC_BITS)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cfg_we_i),
    .steps_i(wr_steps),
    .busy_o (busy),
    .inc_q_o(inc_q),
    .inc_r_o(inc_r)
  );

  cbt_seq #(
    .T_FRAC_BITS(T_FRAC_BITS)
  ) u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .in_data_i (in_data_i),
    .steps_i   (steps_q),
    .busy_i    (busy),
    .inc_q_i   (inc_q),
    .inc_r_i   (inc_r),
    .pt_valid_o(pt_valid),
    .pt_ready_i(pt_ready),
    .pt_seg_o  (pt_seg),
    .pt_ctl_o  (pt_ctl),
    .pt_t_o    (pt_t)
  );

  cbt_pipe #(
    .T_FRAC_BITS(T_FRAC_BITS)
  ) u_pipe (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pt_valid_i (pt_valid),
    .pt_ready_o (pt_ready),
    .pt_seg_i   (pt_seg),
    .pt_ctl_i   (pt_ctl),
    .pt_t_i     (pt_t),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

endmodule

// File: sv/cbt_chk.sv
// port-level checker for the tessellator, bound to the top level
`timescale 1ns / 1ps

module cbt_chk (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            out_valid_o,
  input logic            out_ready_i,
  input cbt_pkg::point_t out_data_o
);

  logic                         xfer;
  logic [cbt_pkg::StepBits-1:0] exp_q;

  assign xfer = out_valid_o & out_ready_i;

  // step index expected on the next output transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_q <= '0;
    end else if (xfer) begin
      exp_q <= out_data_o.last_point ? '0 : out_data_o.step_index + 1'b1;
    end
  end

  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output valid dropped under stall");

  a_data_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_data_o))
    else $error("output data changed under stall");

  a_step_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    xfer |-> out_data_o.step_index == exp_q)
    else $error("points out of step order");

  a_last_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    xfer && out_data_o.last_point |-> out_data_o.step_index != '0)
    else $error("segment ended on its first point");

endmodule

bind cubic_bezier_tessellator_top cbt_chk u_cbt_chk (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_data_o (out_data_o)
);

// File: tb/cubic_bezier_tessellator_top_tb.sv
`timescale 1ns / 1ps
// testbench for the cubic bezier tessellator: directed and random segments checked point by point

module cubic_bezier_tessellator_top_tb;
  import cbt_pkg::*;

  localparam int TFracBits = 16;
  localparam longint TOne = longint'(1) << TFracBits;
  localparam longint THalf = longint'(1) << (TFracBits - 1);
  localparam longint SatHi = (longint'(1) << (CoordBits - 1)) - 1;
  localparam longint SatLo = -(longint'(1) << (CoordBits - 1));
  localparam logic signed [CoordBits-1:0] CoordMax = {1'b0, {(CoordBits-1){1'b1}}};
  localparam logic signed [CoordBits-1:0] CoordMin = {1'b1, {(CoordBits-1){1'b0}}};
  localparam logic signed [CoordBits-1:0] Zc = '0;
  localparam int MaxGap = 12;
  localparam int IdleLimit = 4000;
  localparam int SettleCycles = 8;
  localparam int NumPhases = 9;
  localparam int PhaseSteps[7] = '{4, 0, 1, 63, 9, 2, 31};

  typedef enum logic [1:0] {
    BY_MODEL,
    ENDS_ONLY,
    ALL_ZERO
  } row_kind_e;

  typedef struct {
    row_kind_e kind;
    logic [StepBits-1:0] steps;
    seg_t seg;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  seg_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  point_t out_data_o;
  logic cfg_we_i = 1'b0;
  logic [StepBits-1:0] cfg_wdata_i = '0;

  point_t pending_points[$];
  row_t directed_rows[$];
  logic [StepBits-1:0] step_count = StepsReset;
  bit tx_no_gap = 1'b0;
  bit rx_no_stall = 1'b0;
  int unsigned rx_wait = 0;
  int idle_cycles = 0;
  int error_count = 0;

  cubic_bezier_tessellator_top #(
    .T_FRAC_BITS(TFracBits)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  // product of two Q.16 values, rounded half up
  function automatic longint qprod(longint a, longint b);
    return (a * b + THalf) >>> TFracBits;
  endfunction

  function automatic logic signed [CoordBits-1:0] blend_axis(input longint w[4],
                                                              input longint p[4]);
    longint acc;
    acc = THalf;
    for (int i = 0; i < 4; i++) acc += w[i] * p[i];
    acc = acc >>> TFracBits;  // floor, also for negative sums
    if (acc > SatHi) acc = SatHi;
    if (acc < SatLo) acc = SatLo;
    return CoordBits'(acc);
  endfunction

  function automatic void predict_curve(seg_t s, logic [StepBits-1:0] cfg);
    longint n, j, t, u, t2, u2;
    longint w[4];
    longint px[4];
    longint py[4];
    point_t pt;
    n = (cfg == 0) ? 1 : longint'(cfg);
    px[0] = s.p0_x; px[1] = s.p1_x; px[2] = s.p2_x; px[3] = s.p3_x;
    py[0] = s.p0_y; py[1] = s.p1_y; py[2] = s.p2_y; py[3] = s.p3_y;
    for (j = 0; j <= n; j++) begin
      t = (j * TOne * 2 + n) / (2 * n);
      u = TOne - t;
      t2 = qprod(t, t);
      u2 = qprod(u, u);
      w[0] = qprod(u2, u);
      w[1] = 3 * qprod(t, u2);
      w[2] = 3 * qprod(t2, u);
      w[3] = qprod(t2, t);
      pt.curve_x = blend_axis(w, px);
      pt.curve_y = blend_axis(w, py);
      pt.step_index = StepBits'(j);
      pt.last_point = (j == n);
      pending_points.push_back(pt);
    end
  endfunction

  function automatic logic signed [CoordBits-1:0] pick_coord();
    case ($urandom_range(0, 4))
      0: return CoordMax - CoordBits'($urandom_range(0, 255));
      1: return CoordMin + CoordBits'($urandom_range(0, 255));
      2: return CoordBits'($urandom_range(0, 1023)) - CoordBits'(512);
      3: return CoordBits'($urandom_range(0, 2)) - CoordBits'(1);
      default: return CoordBits'($urandom());
    endcase
  endfunction

  function automatic seg_t rand_segment();
    seg_t s;
    s.p0_x = pick_coord();
    s.p0_y = pick_coord();
    s.p1_x = pick_coord();
    s.p1_y = pick_coord();
    s.p2_x = pick_coord();
    s.p2_y = pick_coord();
    s.p3_x = pick_coord();
    s.p3_y = pick_coord();
    // closed segments now and then
    if ($urandom_range(0, 7) == 0) begin
      s.p3_x = s.p0_x;
      s.p3_y = s.p0_y;
    end
    return s;
  endfunction

  function automatic void add_row(row_kind_e kind, logic [StepBits-1:0] steps, seg_t seg);
    row_t r;
    r.kind = kind;
    r.steps = steps;
    r.seg = seg;
    directed_rows.push_back(r);
  endfunction

  task automatic send_segment(seg_t s);
    int unsigned gap;
    gap = tx_no_gap ? 0 : $urandom_range(0, MaxGap);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= s;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // hold the sender until every outstanding point has come out
  task automatic drain_points();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_points.size() != 0);
  endtask

  task automatic set_step_count(logic [StepBits-1:0] v);
    drain_points();
    repeat (SettleCycles) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    step_count = v;
  endtask

  // receiver: check each transfer, then stall a drawn number of cycles
  always @(posedge clk_i) begin
    point_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (pending_points.size() == 0) begin
          $error("unexpected point: x %0d y %0d step %0d", out_data_o.curve_x,
                 out_data_o.curve_y, out_data_o.step_index);
          error_count++;
        end else begin
          want = pending_points.pop_front();
          if (out_data_o.curve_x !== want.curve_x) begin
            $error("curve_x: expected %0d, got %0d", want.curve_x, out_data_o.curve_x);
            error_count++;
          end
          if (out_data_o.curve_y !== want.curve_y) begin
            $error("curve_y: expected %0d, got %0d", want.curve_y, out_data_o.curve_y);
            error_count++;
          end
          if (out_data_o.step_index !== want.step_index) begin
            $error("step_index: expected %0d, got %0d", want.step_index,
                   out_data_o.step_index);
            error_count++;
          end
          if (out_data_o.last_point !== want.last_point) begin
            $error("last_point: expected %0d, got %0d", want.last_point,
                   out_data_o.last_point);
            error_count++;
          end
        end
        rx_wait = rx_no_stall ? 0 : $urandom_range(0, MaxGap);
        out_ready_i <= (rx_wait == 0);
      end else if (!out_ready_i) begin
        if (rx_wait > 0) rx_wait--;
        if (rx_wait == 0) out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IdleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    row_t row;
    seg_t seg;
    point_t pt;
    int n;
    int n_items;
    logic [StepBits-1:0] phase_cfg;

    // first rows run at the reset step count, so no write before them
    add_row(ALL_ZERO, 6'd15, '{Zc, Zc, Zc, Zc, Zc, Zc, Zc, Zc});
    add_row(BY_MODEL, 6'd15, '{CoordMax, CoordMax, CoordMax, CoordMax,
                               CoordMax, CoordMax, CoordMax, CoordMax});
    add_row(BY_MODEL, 6'd15, '{CoordMin, CoordMin, CoordMin, CoordMin,
                               CoordMin, CoordMin, CoordMin, CoordMin});
    add_row(BY_MODEL, 6'd15, '{CoordMax, CoordMin, CoordMin, CoordMax,
                               CoordMax, CoordMin, CoordMin, CoordMax});
    add_row(BY_MODEL, 6'd15, '{CoordMin, CoordMax, CoordMax, CoordMax,
                               CoordMin, CoordMin, CoordMax, CoordMin});
    // coincident endpoints with far control points
    add_row(BY_MODEL, 6'd15, '{24'sd1000, -24'sd1000, CoordMax, CoordMin,
                               CoordMin, CoordMax, 24'sd1000, -24'sd1000});
    // tiny values where the rounding halves matter
    add_row(BY_MODEL, 6'd15, '{24'sd1, -24'sd1, 24'sd2, -24'sd2,
                               -24'sd3, 24'sd3, 24'sd1, Zc});
    add_row(BY_MODEL, 6'd15, '{24'sd128, -24'sd128, 24'sd256, -24'sd256,
                               24'sd383, 24'sd127, -24'sd1, 24'sd1});
    // zero steps acts as one: just the two ends
    add_row(ENDS_ONLY, 6'd0, '{CoordMax, CoordMin, Zc, Zc,
                               -24'sd1, 24'sd1, CoordMin, CoordMax});
    add_row(ENDS_ONLY, 6'd0, '{24'sd12345, -24'sd54321, 24'sd77, 24'sd99,
                               -24'sd4096, 24'sd65536, -24'sd300000, 24'sd2500000});
    add_row(ENDS_ONLY, 6'd1, '{CoordMin, CoordMax, CoordMax, CoordMax,
                               CoordMin, CoordMin, CoordMax, CoordMin});
    add_row(ENDS_ONLY, 6'd1, '{-24'sd777, 24'sd555, CoordMax, CoordMax,
                               CoordMin, CoordMin, -24'sd777, 24'sd555});
    add_row(BY_MODEL, 6'd63, '{CoordMin, CoordMin, CoordMax, CoordMax,
                               CoordMin, CoordMax, CoordMax, CoordMax});
    add_row(BY_MODEL, 6'd63, '{Zc, Zc, CoordMax, CoordMin,
                               CoordMin, CoordMax, Zc, Zc});
    add_row(ALL_ZERO, 6'd63, '{Zc, Zc, Zc, Zc, Zc, Zc, Zc, Zc});
    add_row(BY_MODEL, 6'd2, '{-24'sd5000, 24'sd7000, 24'sd30000, -24'sd2,
                              24'sd9, 24'sd100000, -24'sd640, 24'sd3});
    add_row(BY_MODEL, 6'd3, '{CoordMax, Zc, Zc, CoordMax,
                              CoordMin, Zc, Zc, CoordMin});
    add_row(BY_MODEL, 6'd7, '{CoordMax, CoordMax, CoordMax, CoordMax,
                              CoordMax, CoordMax, CoordMax, CoordMax});

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[r]) begin
      row = directed_rows[r];
      if (row.steps != step_count) set_step_count(row.steps);
      send_segment(row.seg);
      n = (step_count == 0) ? 1 : int'(step_count);
      case (row.kind)
        ENDS_ONLY: begin
          pending_points.push_back('{row.seg.p0_x, row.seg.p0_y, 6'd0, 1'b0});
          pending_points.push_back('{row.seg.p3_x, row.seg.p3_y, 6'd1, 1'b1});
        end
        ALL_ZERO: begin
          for (int k = 0; k <= n; k++) begin
            pt.curve_x = '0;
            pt.curve_y = '0;
            pt.step_index = StepBits'(k);
            pt.last_point = (k == n);
            pending_points.push_back(pt);
          end
        end
        default: predict_curve(row.seg, step_count);
      endcase
    end

    for (int p = 0; p < NumPhases; p++) begin
      phase_cfg = (p < 7) ? StepBits'(PhaseSteps[p]) : StepBits'($urandom_range(1, 20));
      if (phase_cfg != step_count) set_step_count(phase_cfg);
      tx_no_gap = ($urandom_range(0, 3) == 0);
      rx_no_stall = ($urandom_range(0, 3) == 0);
      n_items = (phase_cfg >= 31) ? 6 : 20;
      for (int i = 0; i < n_items; i++) begin
        if (p == 0 && i == 10) drain_points();
        seg = rand_segment();
        send_segment(seg);
        predict_curve(seg, step_count);
      end
    end

    drain_points();
    repeat (SettleCycles) @(posedge clk_i);
    if (error_count == 0 && pending_points.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/cbt_pkg.sv
sv/cbt_div.sv
sv/cbt_seq.sv
sv/cbt_pipe.sv
sv/cubic_bezier_tessellator_top.sv
sv/cbt_chk.sv
tb/cubic_bezier_tessellator_top_tb.sv
